// ===== src/permutation_distance_histogram_top_defines.svh =====
// Assertion macros for the permutation distance histogram.
// Used by the top level only; needs clk_i and rst_ni in scope.
`ifndef PERMUTATION_DISTANCE_HISTOGRAM_TOP_DEFINES_SVH
`define PERMUTATION_DISTANCE_HISTOGRAM_TOP_DEFINES_SVH

// same-cycle implication
`define PDH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pdh_pkg.sv =====
// Shared types and constants for the permutation distance histogram.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pdh_pkg;

  localparam int MAX_NODES  = 16;
  localparam int COUNT_BITS = 16;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int SIZE_W     = NODE_W + 1;
  localparam int CELL_W     = 3 * NODE_W;
  localparam int CELL_DEPTH = 1 << CELL_W;

  localparam logic [SIZE_W-1:0]     SIZE_MIN  = SIZE_W'(2);
  localparam logic [SIZE_W-1:0]     SIZE_MAX  = SIZE_W'(MAX_NODES);
  localparam logic [SIZE_W-1:0]     SIZE_RST  = SIZE_W'(MAX_NODES);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_PUSH  = 2'd1,
    REQ_READ  = 2'd2
  } pdh_req_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_COUNT,
    ST_DRAIN,
    ST_READ
  } pdh_state_e;

  // one counter increment leaving the sequencer
  typedef struct packed {
    logic              valid;
    logic              first;
    logic [NODE_W-1:0] offs;
  } pdh_issue_t;

  // counter memory requests that bypass the increment pipeline
  typedef struct packed {
    logic              clr_we;
    logic [CELL_W-1:0] clr_addr;
    logic [CELL_W-1:0] rd_addr;
  } pdh_port_t;

endpackage

`default_nettype wire

// ===== src/pdh_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pdh_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/pdh_incr.sv =====
// Shared read-modify-write unit: forms cell addresses, saturating increment
// with write-to-read forwarding. Depends on pdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdh_incr import pdh_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pdh_issue_t            issue_i,
  input  wire pdh_port_t             port_i,
  input  wire logic [NODE_W-1:0]     lb_rdata_i,
  input  wire logic [COUNT_BITS-1:0] cnt_rdata_i,
  output logic      [CELL_W-1:0]     cnt_raddr_o,
  output logic                       cnt_we_o,
  output logic      [CELL_W-1:0]     cnt_waddr_o,
  output logic      [COUNT_BITS-1:0] cnt_wdata_o,
  output logic                       busy_o
);

  logic [NODE_W-1:0]     a_q, a_d;
  logic [CELL_W-1:0]     addr2;
  logic                  s2_valid_q;
  logic [CELL_W-1:0]     s2_addr_q;
  logic                  fwd_valid_q;
  logic [CELL_W-1:0]     fwd_addr_q;
  logic [COUNT_BITS-1:0] fwd_data_q;
  logic [COUNT_BITS-1:0] old_val, new_val;

  // distance 0 reads the reference node itself
  assign a_d   = issue_i.first ? lb_rdata_i : a_q;
  assign addr2 = {a_d, issue_i.offs, lb_rdata_i};

  assign cnt_raddr_o = issue_i.valid ? addr2 : port_i.rd_addr;

  assign old_val = (fwd_valid_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : cnt_rdata_i;
  assign new_val = (old_val == COUNT_MAX) ? old_val : old_val + COUNT_BITS'(1);

  assign cnt_we_o    = s2_valid_q || port_i.clr_we;
  assign cnt_waddr_o = port_i.clr_we ? port_i.clr_addr : s2_addr_q;
  assign cnt_wdata_o = port_i.clr_we ? '0 : new_val;
  assign busy_o      = s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      s2_valid_q  <= issue_i.valid;
      fwd_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      a_q <= a_d;
    end
    s2_addr_q  <= addr2;
    fwd_addr_q <= s2_addr_q;
    fwd_data_q <= new_val;
  end

endmodule

`default_nettype wire

// ===== src/pdh_ctrl.sv =====
// Sequencer: request decode, size register, fill pointer, position loops,
// clearing sweep and result registers. Depends on pdh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pdh_ctrl import pdh_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy_o,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [NODE_W-1:0]     gene_value_i,
  input  wire logic [NODE_W-1:0]     ref_node_i,
  input  wire logic [NODE_W-1:0]     offset_dist_i,
  input  wire logic [NODE_W-1:0]     follow_node_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [SIZE_W-1:0]     cfg_data_i,
  input  wire logic                  unit_busy_i,
  input  wire logic [COUNT_BITS-1:0] cnt_rdata_i,
  output pdh_issue_t                 issue_o,
  output pdh_port_t                  port_o,
  output logic                       lb_we_o,
  output logic      [NODE_W-1:0]     lb_waddr_o,
  output logic      [NODE_W-1:0]     lb_wdata_o,
  output logic      [NODE_W-1:0]     lb_raddr_o,
  output logic                       done_o,
  output logic      [COUNT_BITS-1:0] count_value_o,
  output logic                       status_o,
  output logic                       perm_done_o,
  output logic      [15:0]           samples_done_o
);

  pdh_state_e state_q, state_d;

  logic [SIZE_W-1:0]     size_q, size_d;
  logic [SIZE_W-1:0]     fill_q, fill_d;
  logic [15:0]           sample_q, sample_d;
  logic [CELL_W-1:0]     sweep_q, sweep_d;
  logic [NODE_W-1:0]     i_q, i_d, d_q, d_d, j_q, j_d;
  pdh_issue_t            issue_q, issue_d;
  logic                  done_q, done_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  status_q, status_d;
  logic                  pdone_q, pdone_d;

  logic [SIZE_W-1:0] n;
  logic [NODE_W-1:0] nm1;
  logic              accept;
  logic              gene_bad, read_bad;
  logic [NODE_W-1:0] pos;
  logic [SIZE_W-1:0] fill_next;
  logic              last_elem, loop_end, sweep_end;

  assign n   = (size_q < SIZE_MIN) ? SIZE_MIN : ((size_q > SIZE_MAX) ? SIZE_MAX : size_q);
  assign nm1 = NODE_W'(n - SIZE_W'(1));

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start && !busy_o;

  assign gene_bad = ({1'b0, gene_value_i} >= n);
  assign read_bad = ({1'b0, ref_node_i} >= n) || ({1'b0, offset_dist_i} >= n)
                    || ({1'b0, follow_node_i} >= n);

  assign pos       = (fill_q >= n) ? '0 : fill_q[NODE_W-1:0];
  assign fill_next = {1'b0, pos} + SIZE_W'(1);
  assign last_elem = (fill_next >= n);
  assign loop_end  = (i_q == nm1) && (d_q == nm1);
  assign sweep_end = (sweep_q == '1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        if (sweep_end) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_CLEAR: state_d = ST_CLEAR;
            REQ_PUSH:  if (!gene_bad && last_elem) state_d = ST_COUNT;
            REQ_READ:  if (!read_bad) state_d = ST_READ;
            default:   state_d = ST_IDLE;
          endcase
        end
      end
      ST_COUNT: begin
        if (loop_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!issue_q.valid && !unit_busy_i) state_d = ST_IDLE;
      end
      ST_READ:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    size_d          = size_q;
    fill_d          = fill_q;
    sample_d        = sample_q;
    sweep_d         = sweep_q;
    i_d             = i_q;
    d_d             = d_q;
    j_d             = j_q;
    issue_d         = '0;
    done_d          = 1'b0;
    count_d         = '0;
    status_d        = 1'b0;
    pdone_d         = 1'b0;
    port_o.clr_we   = 1'b0;
    port_o.clr_addr = sweep_q;
    port_o.rd_addr  = {ref_node_i, offset_dist_i, follow_node_i};
    lb_we_o         = 1'b0;
    lb_waddr_o      = pos;
    lb_wdata_o      = gene_value_i;
    lb_raddr_o      = j_q;

    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        port_o.clr_we = 1'b1;
        sweep_d       = sweep_q + CELL_W'(1);
        if (sweep_end && state_q == ST_CLEAR) begin
          done_d = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_CLEAR: begin
              sample_d = '0;
              sweep_d  = '0;
            end
            REQ_PUSH: begin
              if (gene_bad) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end else begin
                lb_we_o = 1'b1;
                if (last_elem) begin
                  fill_d = '0;
                  i_d    = '0;
                  d_d    = '0;
                  j_d    = '0;
                end else begin
                  fill_d = fill_next;
                  done_d = 1'b1;
                end
              end
            end
            REQ_READ: begin
              if (read_bad) begin
                done_d   = 1'b1;
                status_d = 1'b1;
              end
            end
            default: begin
              done_d   = 1'b1;
              status_d = 1'b1;
            end
          endcase
        end
      end
      ST_COUNT: begin
        issue_d.valid = 1'b1;
        issue_d.first = (d_q == '0);
        issue_d.offs  = d_q;
        if (d_q == nm1) begin
          d_d = '0;
          i_d = i_q + NODE_W'(1);
          j_d = i_q + NODE_W'(1);
        end else begin
          d_d = d_q + NODE_W'(1);
          j_d = (j_q == nm1) ? '0 : j_q + NODE_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!issue_q.valid && !unit_busy_i) begin
          done_d  = 1'b1;
          pdone_d = 1'b1;
          if (sample_q != '1) sample_d = sample_q + 16'd1;
        end
      end
      ST_READ: begin
        done_d  = 1'b1;
        count_d = cnt_rdata_i;
      end
      default: begin
        done_d = 1'b0;
      end
    endcase

    // size writes drop a partly pushed permutation
    if (cfg_we_i) begin
      size_d = cfg_data_i;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_INIT;
      size_q   <= SIZE_RST;
      fill_q   <= '0;
      sample_q <= '0;
      sweep_q  <= '0;
      issue_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      size_q   <= size_d;
      fill_q   <= fill_d;
      sample_q <= sample_d;
      sweep_q  <= sweep_d;
      issue_q  <= issue_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q      <= i_d;
    d_q      <= d_d;
    j_q      <= j_d;
    count_q  <= count_d;
    status_q <= status_d;
    pdone_q  <= pdone_d;
  end

  assign issue_o        = issue_q;
  assign done_o         = done_q;
  assign count_value_o  = count_q;
  assign status_o       = status_q;
  assign perm_done_o    = pdone_q;
  assign samples_done_o = sample_q;

endmodule

`default_nettype wire

// ===== src/permutation_distance_histogram_top.sv =====
// Push that does not finish a permutation, bad request: result in the cycle after accept.
// Read: the counter memory read is registered, then the result registers. Clear: one counter cleared per cycle.
// Final push of a permutation of size n: one counter increment per cycle
// through the shared read-modify-write unit; the next item is taken as its result shows.
// Reset: counters are swept to zero with busy high; size resets to 16.
// Results are strobed on done_o for one cycle; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
`include "permutation_distance_histogram_top_defines.svh"

module permutation_distance_histogram_top import pdh_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            req_type_i,
  input  wire logic [NODE_W-1:0]     gene_value_i,
  input  wire logic [NODE_W-1:0]     ref_node_i,
  input  wire logic [NODE_W-1:0]     offset_dist_i,
  input  wire logic [NODE_W-1:0]     follow_node_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [SIZE_W-1:0]     cfg_data_i,
  output logic                       done_o,
  output logic      [COUNT_BITS-1:0] count_value_o,
  output logic                       status_o,
  output logic                       perm_done_o,
  output logic      [15:0]           samples_done_o
);

  pdh_issue_t            issue;
  pdh_port_t             port;
  logic                  unit_busy;
  logic                  lb_we;
  logic [NODE_W-1:0]     lb_waddr, lb_wdata, lb_raddr, lb_rdata;
  logic [CELL_W-1:0]     cnt_raddr, cnt_waddr;
  logic                  cnt_we;
  logic [COUNT_BITS-1:0] cnt_wdata, cnt_rdata;
  logic                  accept;
  logic                  perm_res;

  pdh_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy_o         (busy),
    .req_type_i     (req_type_i),
    .gene_value_i   (gene_value_i),
    .ref_node_i     (ref_node_i),
    .offset_dist_i  (offset_dist_i),
    .follow_node_i  (follow_node_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .unit_busy_i    (unit_busy),
    .cnt_rdata_i    (cnt_rdata),
    .issue_o        (issue),
    .port_o         (port),
    .lb_we_o        (lb_we),
    .lb_waddr_o     (lb_waddr),
    .lb_wdata_o     (lb_wdata),
    .lb_raddr_o     (lb_raddr),
    .done_o         (done_o),
    .count_value_o  (count_value_o),
    .status_o       (status_o),
    .perm_done_o    (perm_done_o),
    .samples_done_o (samples_done_o)
  );

  pdh_incr u_incr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .port_i      (port),
    .lb_rdata_i  (lb_rdata),
    .cnt_rdata_i (cnt_rdata),
    .cnt_raddr_o (cnt_raddr),
    .cnt_we_o    (cnt_we),
    .cnt_waddr_o (cnt_waddr),
    .cnt_wdata_o (cnt_wdata),
    .busy_o      (unit_busy)
  );

  pdh_ram #(
    .WIDTH (NODE_W),
    .DEPTH (MAX_NODES)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (lb_we),
    .waddr_i (lb_waddr),
    .wdata_i (lb_wdata),
    .raddr_i (lb_raddr),
    .rdata_o (lb_rdata)
  );

  pdh_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (CELL_DEPTH)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  assign accept   = start && !busy;
  assign perm_res = done_o && perm_done_o;

  `PDH_ASSERT_NEXT(a_clear_busy, accept && (req_type_i == REQ_CLEAR), busy, "clear not started")
  `PDH_ASSERT_NOW(a_perm_fields, perm_res, !status_o && (count_value_o == '0), "bad perm fields")
  `PDH_ASSERT_NOW(a_perm_count, perm_res, samples_done_o != '0, "sample total not advanced")

endmodule

`default_nettype wire
